[hw/rtl/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master package
// Shared types and constants for the I2C master transfer engine: the bus
// sequencer phases, the tick item and result layouts and the fixed limits.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Largest number of data bytes in one transfer; longer requests saturate.
    localparam logic [7:0] MAX_LENGTH = 8'd255;

    // Reset value of the clock stretching timeout register.
    localparam logic [14:0] STRETCH_RESET = 15'd1000;

    // Bit positions within a byte slot: seven is the last data bit, eight the ACK.
    localparam logic [3:0] BIT_LAST = 4'd7;
    localparam logic [3:0] BIT_ACK  = 4'd8;

    // Value loaded into the shift register before a read byte (SDA released).
    localparam logic [7:0] RX_FILL = 8'hFF;

    // Bus sequencer phases.
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_ST_SDA = 4'd1,
        PH_ST_SCL = 4'd2,
        PH_B_SDA  = 4'd3,
        PH_B_SCL  = 4'd4,
        PH_B_WAIT = 4'd5,
        PH_B_LOW  = 4'd6,
        PH_SP_SDA = 4'd7,
        PH_SP_SCL = 4'd8,
        PH_SP_END = 4'd9
    } phase_t;

    // One tick item: command fields and the sampled bus lines.
    typedef struct packed {
        logic       start_cmd;
        logic       mode;
        logic [6:0] dev_addr;
        logic [7:0] length;
        logic [7:0] tx_byte;
        logic       scl_in;
        logic       sda_in;
    } i2cm_item_t;

    // One tick result: line drives and status.
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       tx_take;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       done_res;
        logic [7:0] transferred;
        logic       addr_nack;
    } i2cm_result_t;

endpackage

[hw/rtl/i2c_master_transfer.sv]
// ----------------------------------------------------------------------------
// I2C master transfer engine
// A tick item's result is registered in the m_ output stage, or in the skid entry
// while m_ready is low. Throughput: one item per cycle while s_ready is high, set
// by the single registered pass through the bus sequencer; a two-entry output stage
// lets an item in while one result waits. Reset (aresetn low, synchronous) idles
// the sequencer with both lines released and sets stretch_timeout to 1000.
// ----------------------------------------------------------------------------
module i2c_master_transfer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_start_cmd,
    input  logic        s_mode,
    input  logic [6:0]  s_dev_addr,
    input  logic [7:0]  s_length,
    input  logic [7:0]  s_tx_byte,
    input  logic        s_scl_in,
    input  logic        s_sda_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_out,
    output logic        m_sda_out,
    output logic        m_busy_res,
    output logic        m_tx_take,
    output logic        m_rx_valid,
    output logic [7:0]  m_rx_byte,
    output logic        m_done_res,
    output logic [7:0]  m_transferred,
    output logic        m_addr_nack,

    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data
);
    import i2cm_pkg::*;

    i2cm_item_t   item;
    i2cm_result_t result;
    i2cm_result_t out_reg;
    i2cm_result_t skid_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic         accept;
    logic         out_load;
    logic         skid_load;
    logic         skid_move;

    // Gather the input item.
    always_comb begin
        item.start_cmd = s_start_cmd;
        item.mode      = s_mode;
        item.dev_addr  = s_dev_addr;
        item.length    = s_length;
        item.tx_byte   = s_tx_byte;
        item.scl_in    = s_scl_in;
        item.sda_in    = s_sda_in;
    end

    // Handshake: an item is taken whenever the skid entry is free.
    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign skid_move = skid_valid_reg && m_ready;
    assign out_load  = accept && (!out_valid_reg || m_ready);
    assign skid_load = accept && out_valid_reg && !m_ready;

    i2cm_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (accept),
        .item        (item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (result)
    );

    // Output stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_move || out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (skid_move) begin
                skid_valid_reg <= 1'b0;
            end else if (skid_load) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Output stage payload.
    always_ff @(posedge aclk) begin
        if (skid_move) begin
            out_reg <= skid_reg;
        end else if (out_load) begin
            out_reg <= result;
        end
        if (skid_load) begin
            skid_reg <= result;
        end
    end

    // Result ports.
    assign m_valid       = out_valid_reg;
    assign m_scl_out     = out_reg.scl_out;
    assign m_sda_out     = out_reg.sda_out;
    assign m_busy_res    = out_reg.busy_res;
    assign m_tx_take     = out_reg.tx_take;
    assign m_rx_valid    = out_reg.rx_valid;
    assign m_rx_byte     = out_reg.rx_byte;
    assign m_done_res    = out_reg.done_res;
    assign m_transferred = out_reg.transferred;
    assign m_addr_nack   = out_reg.addr_nack;

endmodule

[hw/rtl/i2cm_engine.sv]
// ----------------------------------------------------------------------------
// I2C master bus sequencer
// Holds the transfer state and advances it by one pin action for every tick
// item presented with step high. The result of the tick is produced
// combinationally from the updated state.
// ----------------------------------------------------------------------------
module i2cm_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  i2cm_pkg::i2cm_item_t  item,
    input  logic                  cfg_wr_en,
    input  logic [14:0]           cfg_wr_data,
    output i2cm_pkg::i2cm_result_t result
);
    import i2cm_pkg::*;

    phase_t      phase_reg,         phase_next;
    logic [3:0]  bit_index_reg,     bit_index_next;
    logic [7:0]  shift_reg_reg,     shift_reg_next;
    logic [7:0]  byte_counter_reg,  byte_counter_next;
    logic [7:0]  length_held_reg,   length_held_next;
    logic        read_mode_reg,     read_mode_next;
    logic [14:0] stretch_count_reg, stretch_count_next;
    logic        scl_drive_reg,     scl_drive_next;
    logic        sda_drive_reg,     sda_drive_next;
    logic        addr_seg_reg,      addr_seg_next;
    logic        ack_bit_reg,       ack_bit_next;
    logic        nack_flag_reg,     nack_flag_next;
    logic [7:0]  rx_hold_reg,       rx_hold_next;
    logic [14:0] stretch_timeout_reg;

    logic        take;
    logic        rxv;
    logic        done;
    logic        more;
    logic [7:0]  count_inc;

    // Next state for one tick.
    always_comb begin
        phase_next         = phase_reg;
        bit_index_next     = bit_index_reg;
        shift_reg_next     = shift_reg_reg;
        byte_counter_next  = byte_counter_reg;
        length_held_next   = length_held_reg;
        read_mode_next     = read_mode_reg;
        stretch_count_next = stretch_count_reg;
        scl_drive_next     = scl_drive_reg;
        sda_drive_next     = sda_drive_reg;
        addr_seg_next      = addr_seg_reg;
        ack_bit_next       = ack_bit_reg;
        nack_flag_next     = nack_flag_reg;
        rx_hold_next       = rx_hold_reg;
        take               = 1'b0;
        rxv                = 1'b0;
        done               = 1'b0;
        more               = 1'b0;
        count_inc          = byte_counter_reg + 8'd1;

        case (phase_reg)
            PH_IDLE: begin
                if (item.start_cmd) begin
                    read_mode_next    = item.mode;
                    shift_reg_next    = {item.dev_addr, item.mode};
                    length_held_next  = (item.length > MAX_LENGTH) ? MAX_LENGTH : item.length;
                    byte_counter_next = 8'd0;
                    bit_index_next    = 4'd0;
                    addr_seg_next     = 1'b1;
                    nack_flag_next    = 1'b0;
                    scl_drive_next    = 1'b1;
                    sda_drive_next    = 1'b1;
                    phase_next        = PH_ST_SDA;
                end
            end
            PH_ST_SDA: begin
                sda_drive_next = 1'b0;
                phase_next     = PH_ST_SCL;
            end
            PH_ST_SCL: begin
                scl_drive_next = 1'b0;
                bit_index_next = 4'd0;
                phase_next     = PH_B_SDA;
            end
            PH_B_SDA: begin
                // Data bits go out MSB first; in a read the master ACKs all but the last byte.
                if (bit_index_reg < BIT_ACK) begin
                    sda_drive_next = shift_reg_reg[7];
                end else if (addr_seg_reg || !read_mode_reg) begin
                    sda_drive_next = 1'b1;
                end else begin
                    sda_drive_next = !(byte_counter_reg < length_held_reg);
                end
                phase_next = PH_B_SCL;
            end
            PH_B_SCL: begin
                scl_drive_next     = 1'b1;
                stretch_count_next = 15'd0;
                phase_next         = PH_B_WAIT;
            end
            PH_B_WAIT: begin
                // Wait for SCL to read high, or give up once the timeout is spent.
                if (item.scl_in || (stretch_count_reg >= stretch_timeout_reg)) begin
                    if (bit_index_reg < BIT_ACK) begin
                        shift_reg_next = {shift_reg_reg[6:0], item.sda_in};
                    end else begin
                        ack_bit_next = item.sda_in;
                    end
                    phase_next = PH_B_LOW;
                end else begin
                    stretch_count_next = stretch_count_reg + 15'd1;
                end
            end
            PH_B_LOW: begin
                scl_drive_next = 1'b0;
                if (bit_index_reg < BIT_LAST) begin
                    bit_index_next = bit_index_reg + 4'd1;
                    phase_next     = PH_B_SDA;
                end else if (bit_index_reg == BIT_LAST) begin
                    bit_index_next = BIT_ACK;
                    if (!addr_seg_reg && read_mode_reg) begin
                        rx_hold_next      = shift_reg_reg;
                        rxv               = 1'b1;
                        byte_counter_next = count_inc;
                    end
                    phase_next = PH_B_SDA;
                end else if (addr_seg_reg && ack_bit_reg) begin
                    // Address NACK: flag it and stop at once.
                    nack_flag_next = 1'b1;
                    phase_next     = PH_SP_SDA;
                end else if (!addr_seg_reg && !read_mode_reg && ack_bit_reg) begin
                    // Data NACK in a write: the byte is not counted.
                    phase_next = PH_SP_SDA;
                end else begin
                    addr_seg_next = 1'b0;
                    if (!addr_seg_reg && !read_mode_reg) begin
                        byte_counter_next = count_inc;
                        more              = count_inc < length_held_reg;
                    end else begin
                        more = byte_counter_reg < length_held_reg;
                    end
                    if (!more) begin
                        phase_next = PH_SP_SDA;
                    end else begin
                        if (read_mode_reg) begin
                            shift_reg_next = RX_FILL;
                        end else begin
                            shift_reg_next = item.tx_byte;
                            take           = 1'b1;
                        end
                        bit_index_next = 4'd0;
                        phase_next     = PH_B_SDA;
                    end
                end
            end
            PH_SP_SDA: begin
                sda_drive_next = 1'b0;
                phase_next     = PH_SP_SCL;
            end
            PH_SP_SCL: begin
                scl_drive_next = 1'b1;
                phase_next     = PH_SP_END;
            end
            PH_SP_END: begin
                sda_drive_next = 1'b1;
                done           = 1'b1;
                phase_next     = PH_IDLE;
            end
            default: begin
                scl_drive_next = 1'b1;
                sda_drive_next = 1'b1;
                phase_next     = PH_IDLE;
            end
        endcase
    end

    // Result of the tick, taken from the updated state.
    always_comb begin
        result.scl_out     = scl_drive_next;
        result.sda_out     = sda_drive_next;
        result.busy_res    = (phase_next != PH_IDLE);
        result.tx_take     = take;
        result.rx_valid    = rxv;
        result.rx_byte     = rx_hold_next;
        result.done_res    = done;
        result.transferred = done ? byte_counter_reg : 8'd0;
        result.addr_nack   = done & nack_flag_reg;
    end

    // Transfer state registers, advanced once per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            bit_index_reg     <= 4'd0;
            shift_reg_reg     <= 8'd0;
            byte_counter_reg  <= 8'd0;
            length_held_reg   <= 8'd0;
            read_mode_reg     <= 1'b0;
            stretch_count_reg <= 15'd0;
            scl_drive_reg     <= 1'b1;
            sda_drive_reg     <= 1'b1;
            addr_seg_reg      <= 1'b0;
            ack_bit_reg       <= 1'b0;
            nack_flag_reg     <= 1'b0;
            rx_hold_reg       <= 8'd0;
        end else if (step) begin
            phase_reg         <= phase_next;
            bit_index_reg     <= bit_index_next;
            shift_reg_reg     <= shift_reg_next;
            byte_counter_reg  <= byte_counter_next;
            length_held_reg   <= length_held_next;
            read_mode_reg     <= read_mode_next;
            stretch_count_reg <= stretch_count_next;
            scl_drive_reg     <= scl_drive_next;
            sda_drive_reg     <= sda_drive_next;
            addr_seg_reg      <= addr_seg_next;
            ack_bit_reg       <= ack_bit_next;
            nack_flag_reg     <= nack_flag_next;
            rx_hold_reg       <= rx_hold_next;
        end
    end

    // Clock stretching timeout register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stretch_timeout_reg <= STRETCH_RESET;
        end else if (cfg_wr_en) begin
            stretch_timeout_reg <= cfg_wr_data;
        end
    end

endmodule
